@@ rtl/core/sai_pkg.sv @@
// shared constants and controller/datapath interface types for the sorted insertion list
`default_nettype none

package sai_pkg;

  localparam int Depth = 16;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  localparam int ValueW = 32;
  localparam int IndexW = 4;
  localparam int StatW  = 2;
  localparam int PosW   = 5;

  localparam logic [StatW-1:0] StatusOk    = 2'd0;
  localparam logic [StatW-1:0] StatusFull  = 2'd1;
  localparam logic [StatW-1:0] StatusRange = 2'd2;

  localparam logic ModeInsert = 1'b0;
  localparam logic ModeRead   = 1'b1;

  // commands from the controller to the datapath
  typedef struct packed {
    logic accept;     // capture the request, k = count
    logic rd_index;   // read entry at requested index
    logic rd_top;     // read highest stored entry
    logic rd_next;    // read entry below the one just moved
    logic shift;      // move read entry up to slot k, k = k - 1
    logic place;      // write value at slot k, count + 1, result ok
    logic res_full;   // result: insert dropped
    logic res_range;  // result: read out of range
    logic res_read;   // result: read data
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic full;        // store holds Depth entries
    logic empty;       // store holds no entries
    logic index_oob;   // requested index at or beyond count
    logic greater;     // last read entry strictly greater than value
    logic k_one;       // slot pointer is one
  } stat_t;

endpackage

`default_nettype wire

@@ rtl/core/sai_datapath.sv @@
// entry memory, count, slot pointer and result registers of the sorted insertion list
`default_nettype none

module sai_datapath
  import sai_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire cmd_t                     cmd_i,
  output stat_t                         stat_o,
  input  wire logic signed [ValueW-1:0] value_i,
  input  wire logic        [IndexW-1:0] index_i,
  output logic             [StatW-1:0]  status_o,
  output logic             [PosW-1:0]   position_o,
  output logic             [PosW-1:0]   count_o,
  output logic signed      [ValueW-1:0] read_value_o
);

  logic        [ValueW-1:0] mem [Depth];
  logic        [ValueW-1:0] rdata_q;
  logic signed [ValueW-1:0] value_q;
  logic        [CntW-1:0]   count_q, count_d;
  logic        [CntW-1:0]   k_q, k_d;
  logic        [AddrW-1:0]  rd_addr;
  logic                     rd_en;

  logic        [StatW-1:0]  status_q;
  logic        [PosW-1:0]   position_q;
  logic signed [ValueW-1:0] read_value_q;

  assign rd_en = cmd_i.rd_index | cmd_i.rd_top | cmd_i.rd_next;

  always_comb begin
    priority if (cmd_i.rd_index) begin
      rd_addr = AddrW'(index_i);
    end else if (cmd_i.rd_top) begin
      rd_addr = AddrW'(count_q - CntW'(1));
    end else begin
      rd_addr = AddrW'(k_q - CntW'(2));
    end
  end

  // single write port, single registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.shift) begin
      mem[AddrW'(k_q)] <= rdata_q;
    end else if (cmd_i.place) begin
      mem[AddrW'(k_q)] <= value_q;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.place) begin
      count_d = count_q + CntW'(1);
    end
  end

  always_comb begin
    k_d = k_q;
    if (cmd_i.accept) begin
      k_d = count_q;
    end else if (cmd_i.shift) begin
      k_d = k_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q <= k_d;
    if (cmd_i.accept) begin
      value_q <= value_i;
    end
  end

  // result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.place) begin
      status_q     <= StatusOk;
      position_q   <= PosW'(k_q);
      read_value_q <= '0;
    end else if (cmd_i.res_full) begin
      status_q     <= StatusFull;
      position_q   <= '0;
      read_value_q <= '0;
    end else if (cmd_i.res_range) begin
      status_q     <= StatusRange;
      position_q   <= '0;
      read_value_q <= '0;
    end else if (cmd_i.res_read) begin
      status_q     <= StatusOk;
      position_q   <= '0;
      read_value_q <= rdata_q;
    end
  end

  assign stat_o.full      = (count_q == CntW'(Depth));
  assign stat_o.empty     = (count_q == '0);
  assign stat_o.index_oob = (32'(index_i) >= 32'(count_q));
  assign stat_o.greater   = ($signed(rdata_q) > value_q);
  assign stat_o.k_one     = (k_q == CntW'(1));

  assign status_o     = status_q;
  assign position_o   = position_q;
  assign count_o      = PosW'(count_q);
  assign read_value_o = read_value_q;

endmodule

`default_nettype wire

@@ rtl/core/sai_ctrl.sv @@
// sequencing state machine of the sorted insertion list
`default_nettype none

module sai_ctrl
  import sai_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  wire logic  mode_i,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  input  wire stat_t stat_i,
  output cmd_t       cmd_o
);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StRdWait = 3'd1;
  localparam logic [2:0] StScan   = 3'd2;
  localparam logic [2:0] StPlace  = 3'd3;
  localparam logic [2:0] StOut    = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (mode_i == ModeRead) begin
            if (stat_i.index_oob) begin
              cmd_o.res_range = 1'b1;
              state_d         = StOut;
            end else begin
              cmd_o.rd_index = 1'b1;
              state_d        = StRdWait;
            end
          end else begin
            if (stat_i.full) begin
              cmd_o.res_full = 1'b1;
              state_d        = StOut;
            end else if (stat_i.empty) begin
              state_d = StPlace;
            end else begin
              cmd_o.rd_top = 1'b1;
              state_d      = StScan;
            end
          end
        end
      end
      StRdWait: begin
        cmd_o.res_read = 1'b1;
        state_d        = StOut;
      end
      // walk down from the top, moving larger entries up one slot
      StScan: begin
        if (stat_i.greater) begin
          cmd_o.shift = 1'b1;
          if (stat_i.k_one) begin
            state_d = StPlace;
          end else begin
            cmd_o.rd_next = 1'b1;
          end
        end else begin
          state_d = StPlace;
        end
      end
      StPlace: begin
        cmd_o.place = 1'b1;
        state_d     = StOut;
      end
      StOut: begin
        if (out_ready_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StOut);

endmodule

`default_nettype wire

@@ rtl/core/sorted_array_insert.sv @@
// sorted insertion list: top level joining controller and datapath
//
// requests arrive on in_valid_i/in_ready_o with mode_i, value_i and index_i.
// an insert request places value_i after all stored entries that are not
// greater than it; a read request returns the entry at index_i.
// each request yields one result on out_valid_o/out_ready_i with status_o,
// position_o, count_o and read_value_o.
// one request is handled at a time: in_ready_o is high only while idle.
// from acceptance to out_valid_o: a read in range reads the entry, then
// registers it; a read out of range or insert into a full store registers
// its result at acceptance; an insert moves each of the g stored entries
// greater than the value up one slot through the single memory port, then
// places the value, with no scan when the store is empty.
// after out_valid_o is taken the block is ready again in the next cycle.
// a stalled receiver holds the result stable and blocks new requests.
// reset empties the store (count zero); entry contents need no clearing.
`default_nettype none

module sorted_array_insert
  import sai_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic                     mode_i,
  input  wire logic signed [ValueW-1:0] value_i,
  input  wire logic        [IndexW-1:0] index_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic             [StatW-1:0]  status_o,
  output logic             [PosW-1:0]   position_o,
  output logic             [PosW-1:0]   count_o,
  output logic signed      [ValueW-1:0] read_value_o
);

  cmd_t  cmd;
  stat_t stat;

  sai_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  sai_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .value_i      (value_i),
    .index_i      (index_i),
    .status_o     (status_o),
    .position_o   (position_o),
    .count_o      (count_o),
    .read_value_o (read_value_o)
  );

endmodule

`default_nettype wire
